// ===== hw/rtl/kbsc_pkg.sv =====
// kbsc_pkg: shared types and constants of the keyed byte stream cipher
// used by kbsc_ctrl, kbsc_dp and keyed_byte_stream_cipher_core; no dependencies
`default_nettype none

package kbsc_pkg;

    localparam int KEY_BYTES_DEF = 16;
    localparam int KEY_BYTES_MAX = 16;

    localparam int SEED_W  = 13;
    localparam int MIXER_W = 18;
    localparam int KPOS_W  = 4;
    localparam int KLEN_W  = 5;
    localparam int BYTE_W  = 8;
    localparam int REM_W   = 9;
    localparam int BIT_W   = 4;
    localparam int CFG_W   = 64;
    localparam int CIDX_W  = 2;
    localparam int PROD_W  = 22;

    localparam logic [SEED_W-1:0]  SEED_INIT     = 13'd257;
    localparam logic [MIXER_W-1:0] MIXER_INIT    = 18'd13;
    localparam logic [SEED_W:0]    MIX_ADD       = 14'd7;
    localparam logic [KLEN_W-1:0]  KEY_LEN_RESET = 5'd16;
    localparam logic [BIT_W-1:0]   DIV_TOP_BIT   = 4'(SEED_W - 1);

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_KEY_LEN  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_STEP
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic              load_start;
        logic              step_in;
        logic              step_held;
        logic              div_step;
        logic              div_last;
        logic [KPOS_W-1:0] kidx;
        logic [BIT_W-1:0]  bit_idx;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic              out_valid;
        logic [KLEN_W-1:0] used_len;
    } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kbsc_ctrl.sv =====
// kbsc_ctrl: sequencer of the cipher: item handshake and key schedule counters
// depends on kbsc_pkg
`default_nettype none

module kbsc_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           msg_start,
    input  wire logic           out_stall,
    input  wire kbsc_pkg::sts_t sts,
    output logic                in_stall,
    output kbsc_pkg::cmd_t      cmd
);

    kbsc_pkg::state_t              state_reg, state_next;
    logic [kbsc_pkg::KPOS_W-1:0]   kidx_reg, kidx_next;
    logic [kbsc_pkg::BIT_W-1:0]    bit_reg, bit_next;
    logic                          out_free;
    logic                          accept;
    logic                          last_key;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kbsc_pkg::ST_IDLE;
            kidx_reg  <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            kidx_reg  <= kidx_next;
            bit_reg   <= bit_next;
        end
    end

    assign out_free = !sts.out_valid || !out_stall;
    assign last_key = ({1'b0, kidx_reg} + 5'd1) >= sts.used_len;

    always_comb
    begin
        state_next     = state_reg;
        kidx_next      = kidx_reg;
        bit_next       = bit_reg;
        in_stall       = 1'b1;
        accept         = 1'b0;
        cmd            = '0;
        cmd.kidx       = kidx_reg;
        cmd.bit_idx    = bit_reg;
        case (state_reg)
            kbsc_pkg::ST_IDLE:
            begin
                in_stall = !out_free;
                accept   = in_valid && out_free;
                if (accept)
                begin
                    if (msg_start)
                    begin
                        cmd.load_start = 1'b1;
                        kidx_next      = '0;
                        bit_next       = kbsc_pkg::DIV_TOP_BIT;
                        state_next     = kbsc_pkg::ST_DIV;
                    end
                    else
                    begin
                        cmd.step_in = 1'b1;
                    end
                end
            end
            kbsc_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (bit_reg == '0)
                begin
                    cmd.div_last = 1'b1;
                    bit_next     = kbsc_pkg::DIV_TOP_BIT;
                    if (last_key)
                    begin
                        state_next = kbsc_pkg::ST_STEP;
                    end
                    else
                    begin
                        kidx_next = kidx_reg + 4'd1;
                    end
                end
                else
                begin
                    bit_next = bit_reg - 4'd1;
                end
            end
            kbsc_pkg::ST_STEP:
            begin
                if (out_free)
                begin
                    cmd.step_held = 1'b1;
                    state_next    = kbsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kbsc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/kbsc_dp.sv =====
// kbsc_dp: datapath of the cipher: key registers, seed/mixer state,
// restoring remainder unit and output register; depends on kbsc_pkg
`default_nettype none

module kbsc_dp #(
    parameter int KEY_BYTES = kbsc_pkg::KEY_BYTES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [kbsc_pkg::CIDX_W-1:0]   cfg_index,
    input  wire logic [kbsc_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic [kbsc_pkg::BYTE_W-1:0]   data_byte,
    input  wire logic                          out_stall,
    input  wire kbsc_pkg::cmd_t                cmd,
    output kbsc_pkg::sts_t                     sts,
    output logic                               out_valid,
    output logic [kbsc_pkg::BYTE_W-1:0]        out_byte
);

    localparam logic [kbsc_pkg::KLEN_W-1:0] LEN_CAP = kbsc_pkg::KLEN_W'(
        (KEY_BYTES < kbsc_pkg::KEY_BYTES_MAX) ? KEY_BYTES : kbsc_pkg::KEY_BYTES_MAX);

    logic [kbsc_pkg::CFG_W-1:0]    key_low_reg, key_high_reg;
    logic [kbsc_pkg::KLEN_W-1:0]   key_len_reg;
    logic [kbsc_pkg::SEED_W-1:0]   seed_reg, seed_next;
    logic [kbsc_pkg::MIXER_W-1:0]  mixer_reg, mixer_next;
    logic [kbsc_pkg::KPOS_W-1:0]   key_pos_reg, key_pos_next;
    logic [kbsc_pkg::REM_W-1:0]    rem_reg, rem_next;
    logic [kbsc_pkg::BYTE_W-1:0]   data_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [kbsc_pkg::BYTE_W-1:0]   out_byte_reg, out_byte_next;

    logic [kbsc_pkg::KLEN_W-1:0]   used_len;
    logic [2*kbsc_pkg::CFG_W-1:0]  key_all;
    logic [kbsc_pkg::KPOS_W-1:0]   key_sel;
    logic [kbsc_pkg::BYTE_W-1:0]   key_byte;
    logic [kbsc_pkg::REM_W:0]      rem_shift;
    logic [kbsc_pkg::REM_W:0]      divisor;
    logic [kbsc_pkg::REM_W-1:0]    rem_new;
    logic [kbsc_pkg::SEED_W-1:0]   seed_sum;
    logic [kbsc_pkg::SEED_W:0]     mul_a;
    logic [kbsc_pkg::PROD_W-1:0]   product;
    logic [kbsc_pkg::PROD_W-1:0]   mix_sum;
    logic [kbsc_pkg::BYTE_W-1:0]   data_sel;
    logic [kbsc_pkg::KLEN_W-1:0]   pos_inc;
    logic                          do_step;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= kbsc_pkg::KEY_LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                kbsc_pkg::CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                kbsc_pkg::CFG_KEY_HIGH: key_high_reg <= cfg_data;
                kbsc_pkg::CFG_KEY_LEN:  key_len_reg  <= cfg_data[kbsc_pkg::KLEN_W-1:0];
                default:                key_len_reg  <= key_len_reg;
            endcase
        end
    end

    always_comb
    begin
        if (key_len_reg == '0)
            used_len = 5'd1;
        else if (key_len_reg > LEN_CAP)
            used_len = LEN_CAP;
        else
            used_len = key_len_reg;
    end

    // one key byte read: schedule index while dividing, stream position otherwise
    assign key_all  = {key_high_reg, key_low_reg};
    assign key_sel  = cmd.div_step ? cmd.kidx : key_pos_reg;
    assign key_byte = key_all[key_sel*kbsc_pkg::BYTE_W +: kbsc_pkg::BYTE_W];

    // restoring remainder, one dividend bit per cycle
    assign rem_shift = {rem_reg, seed_reg[cmd.bit_idx]};
    assign divisor   = {2'b00, key_byte} + 10'd1;
    assign rem_new   = (rem_shift >= divisor) ? kbsc_pkg::REM_W'(rem_shift - divisor)
                                              : rem_shift[kbsc_pkg::REM_W-1:0];

    // keystream step
    assign seed_sum = seed_reg + {5'b0, key_byte};
    assign mul_a    = {1'b0, seed_sum} + kbsc_pkg::MIX_ADD;
    assign product  = kbsc_pkg::PROD_W'(mul_a * mixer_reg[kbsc_pkg::BYTE_W-1:0]);
    assign mix_sum  = product + {12'b0, mixer_reg[kbsc_pkg::MIXER_W-1:kbsc_pkg::BYTE_W]};
    assign data_sel = cmd.step_in ? data_byte : data_reg;
    assign pos_inc  = {1'b0, key_pos_reg} + 5'd1;
    assign do_step  = cmd.step_in || cmd.step_held;

    always_comb
    begin
        seed_next      = seed_reg;
        mixer_next     = mixer_reg;
        key_pos_next   = key_pos_reg;
        rem_next       = rem_reg;
        out_byte_next  = out_byte_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.load_start)
        begin
            seed_next    = kbsc_pkg::SEED_INIT;
            mixer_next   = kbsc_pkg::MIXER_INIT;
            key_pos_next = '0;
            rem_next     = '0;
        end
        else if (cmd.div_step)
        begin
            rem_next = rem_new;
            if (cmd.div_last)
            begin
                seed_next = seed_reg + {4'b0, rem_new};
                rem_next  = '0;
            end
        end
        else if (do_step)
        begin
            mixer_next     = mix_sum[kbsc_pkg::MIXER_W-1:0];
            seed_next      = {5'b0, mix_sum[kbsc_pkg::BYTE_W-1:0]};
            key_pos_next   = (pos_inc >= used_len) ? '0 : pos_inc[kbsc_pkg::KPOS_W-1:0];
            out_byte_next  = data_sel ^ mix_sum[kbsc_pkg::BYTE_W-1:0];
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= '0;
            mixer_reg     <= kbsc_pkg::MIXER_INIT;
            key_pos_reg   <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seed_reg      <= seed_next;
            mixer_reg     <= mixer_next;
            key_pos_reg   <= key_pos_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        if (cmd.load_start)
            data_reg <= data_byte;
    end

    assign sts.out_valid = out_valid_reg;
    assign sts.used_len  = used_len;
    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/keyed_byte_stream_cipher_core.sv =====
// keyed_byte_stream_cipher_core: top level of the keyed byte stream cipher
// depends on kbsc_pkg, kbsc_ctrl and kbsc_dp
//
// usage
//   - key bytes and key length are written through cfg_wr_en/cfg_index/cfg_data
//     while the core is idle; key_len 0 acts as 1, values above the key size clamp
//   - input items (data_byte, msg_start) arrive on in_valid/in_stall, results
//     (out_byte) leave on out_valid/out_stall; one result per item, in order
//   - an item without msg_start is stepped in its accept cycle; its result sits
//     in the output register in the following cycle, so a message streams one item
//     per cycle while the receiver keeps up
//   - an item with msg_start first runs the key schedule: a restoring remainder
//     unit takes one dividend bit per cycle, every seed bit for each key byte, and
//     the item is then stepped once the output is free; in_stall stays high
//     until then
//   - a stalled receiver holds the output register; a new item is still taken
//     in the cycle the held result is taken
//   - reset clears the key to zero, key length to 16, seed to 0, mixer to 13
//     and key position to 0; bytes sent before any message start run from there
`default_nettype none

module keyed_byte_stream_cipher_core #(
    parameter int KEY_BYTES = kbsc_pkg::KEY_BYTES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration write port
    input  wire logic                         cfg_wr_en,
    input  wire logic [kbsc_pkg::CIDX_W-1:0]  cfg_index,
    input  wire logic [kbsc_pkg::CFG_W-1:0]   cfg_data,
    // input item channel
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [kbsc_pkg::BYTE_W-1:0]  data_byte,
    input  wire logic                         msg_start,
    // result item channel
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [kbsc_pkg::BYTE_W-1:0]       out_byte
);

    kbsc_pkg::cmd_t cmd;
    kbsc_pkg::sts_t sts;

    // sequencer: handshake, key schedule counters
    kbsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .msg_start (msg_start),
        .out_stall (out_stall),
        .sts       (sts),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    // key registers, generator state, remainder unit, output register
    kbsc_dp #(
        .KEY_BYTES (KEY_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .data_byte (data_byte),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_byte  (out_byte)
    );

endmodule

`default_nettype wire
